FILE: design/rmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmp_pkg
// Shared types and constants for the range matrix product segment tree.
// ----------------------------------------------------------------------------
package rmp_pkg;

  localparam int ENTRY_W   = 30;
  localparam int IDX_W     = 10;
  localparam int CNT_MIN_W = 11;
  localparam int PROD_W    = 2 * ENTRY_W;
  localparam int SUM_W     = PROD_W + 1;

  localparam logic [ENTRY_W-1:0] MOD_RESET = 30'd998244353;

  // register indexes, selected by paddr[2]
  localparam logic REG_MODULUS = 1'b0;
  localparam logic REG_COUNT   = 1'b1;

  // one 2x2 matrix, row-major
  typedef struct packed {
    logic [ENTRY_W-1:0] tl;
    logic [ENTRY_W-1:0] tr;
    logic [ENTRY_W-1:0] bl;
    logic [ENTRY_W-1:0] br;
  } mat_t;

  localparam int MAT_W = $bits(mat_t);

  // source of node memory write data
  typedef enum logic [1:0] {
    WR_ZERO = 2'd0,
    WR_LEAF = 2'd1,
    WR_ACC  = 2'd2
  } wr_src_t;

  // controller to datapath commands
  typedef struct packed {
    logic    take_item;
    logic    rd_en;
    logic    wr_en;
    wr_src_t wr_src;
    logic    acc_ident;
    logic    acc_ident_red;
    logic    acc_from_rd;
    logic    mul_start;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic mul_busy;
    logic mul_done;
  } dp_stat_t;

endpackage

FILE: design/range_matrix_product_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_matrix_product_mod
// Segment tree of 2x2 matrices with modular range product queries.
// ----------------------------------------------------------------------------
// Usage:
//   The s_* stream carries requests: tuser is the request type (0 load one
//   leaf matrix, 1 range product query), tdata the indices and the matrix.
//   A query yields one transfer on m_*, a load yields none. The APB port
//   holds the modulus (address 0) and element count (address 4); writing
//   the element count clears every tree node.
//   Items are handled one at a time. Each multiplied tree node costs one
//   modular 2x2 multiply: product stage, lane start and the 61 bit-serial
//   remainder steps. A load rebuilds each ancestor of its leaf with one
//   multiply; a query visits nodes from the root and multiplies each
//   covered node but a covered root, up to about 2 * depth nodes, depth
//   being ceil(log2(count)). A load at or beyond the count changes no node.
//   After reset and after each count write a clearing pass zeroes every
//   slot of the node memory with s_tready low.
//   A finished result sits in the output register; a new request is taken
//   while it waits, and a following query stalls until m_tready takes it.
// ----------------------------------------------------------------------------
module range_matrix_product_mod
  import rmp_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic         clk,
  input  logic         rst,
  // apb configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // request stream
  input  logic         s_tvalid,
  output logic         s_tready,
  // first_index, last_index, entry_top_left, entry_top_right,
  // entry_bottom_left, entry_bottom_right, zero pad
  input  logic [143:0] s_tdata,
  // req_type
  input  logic [0:0]   s_tuser,
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // product_top_left, product_top_right, product_bottom_left,
  // product_bottom_right
  output logic [119:0] m_tdata
);

  localparam int CNT_W  = ($clog2(MAX_ELEMENTS + 1) > CNT_MIN_W) ?
                          $clog2(MAX_ELEMENTS + 1) : CNT_MIN_W;
  localparam int SLOT_W = $clog2(2 * MAX_ELEMENTS);
  localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(MAX_ELEMENTS);

  logic               cfg_wr;
  logic [ENTRY_W-1:0] modulus;
  logic [CNT_W-1:0]   element_count;
  logic [CNT_W-1:0]   count_eff;
  logic [ENTRY_W:0]   modulus_eff;
  logic               clear_req;
  logic               out_free;
  logic               out_load;
  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic [SLOT_W-1:0]  node_addr;
  mat_t               item_mat;
  mat_t               acc_out;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus       <= MOD_RESET;
      element_count <= COUNT_MAX;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_COUNT) begin
        element_count <= CNT_W'(pwdata[10:0]);
      end else begin
        modulus <= pwdata[ENTRY_W-1:0];
      end
    end
  end

  assign clear_req = cfg_wr && (paddr[2] == REG_COUNT);
  assign prdata    = (paddr[2] == REG_COUNT) ? 32'(element_count) : 32'(modulus);

  // working count and modulus, zero modulus acts as 2^30
  always_comb begin
    if (element_count == '0) begin
      count_eff = CNT_W'(1);
    end else if (element_count > COUNT_MAX) begin
      count_eff = COUNT_MAX;
    end else begin
      count_eff = element_count;
    end
    modulus_eff = (modulus == '0) ? {1'b1, {ENTRY_W{1'b0}}} : {1'b0, modulus};
  end

  // unpack the loaded matrix
  assign item_mat = '{tl: s_tdata[49:20], tr: s_tdata[79:50],
                      bl: s_tdata[109:80], br: s_tdata[139:110]};

  rmp_ctrl #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .clear_req  (clear_req),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_req_type(s_tuser[0]),
    .in_first   (s_tdata[9:0]),
    .in_last    (s_tdata[19:10]),
    .count_eff  (count_eff),
    .out_free   (out_free),
    .out_load   (out_load),
    .cmd        (cmd),
    .stat       (stat),
    .node_addr  (node_addr)
  );

  rmp_dpath #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .node_addr  (node_addr),
    .item_mat   (item_mat),
    .modulus_eff(modulus_eff),
    .acc_out    (acc_out)
  );

  // result output register
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {acc_out.br, acc_out.bl, acc_out.tr, acc_out.tl};
    end
  end

endmodule

FILE: design/rmp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmp_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module rmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read, read data holds when idle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/rmp_modred.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmp_modred
// Bit-serial remainder of a product sum by the modulus, one bit per cycle.
// ----------------------------------------------------------------------------
module rmp_modred
  import rmp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [SUM_W-1:0]   dividend,
  input  logic [ENTRY_W:0]   modulus,
  output logic               busy,
  output logic               done,
  output logic [ENTRY_W-1:0] result
);

  localparam int CW = $clog2(SUM_W + 1);

  logic [CW-1:0]      cnt;
  logic [ENTRY_W-1:0] rem;
  logic [SUM_W-1:0]   dvd;
  logic [ENTRY_W:0]   trial;
  logic [ENTRY_W:0]   diff;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial  = {rem, dvd[SUM_W-1]};
    diff   = trial - modulus;
    result = (trial >= modulus) ? diff[ENTRY_W-1:0] : trial[ENTRY_W-1:0];
  end

  assign busy = (cnt != '0);
  assign done = (cnt == CW'(1));

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(SUM_W);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
    end
  end

  // partial remainder and dividend shifter
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
    end else if (busy) begin
      rem <= result;
      dvd <= {dvd[SUM_W-2:0], 1'b0};
    end
  end

endmodule

FILE: design/rmp_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmp_dpath
// Node memory, accumulator matrix and modular 2x2 matrix multiplier.
// ----------------------------------------------------------------------------
module rmp_dpath
  import rmp_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  dp_cmd_t                           cmd,
  output dp_stat_t                          stat,
  input  logic [$clog2(2*MAX_ELEMENTS)-1:0] node_addr,
  input  mat_t                              item_mat,
  input  logic [ENTRY_W:0]                  modulus_eff,
  output mat_t                              acc_out
);

  localparam int SLOTS = 2 * MAX_ELEMENTS;

  mat_t               item;
  mat_t               acc;
  mat_t               rd_mat;
  mat_t               wr_mat;
  logic [PROD_W-1:0]  prod [8];
  logic               p_valid;
  logic [SUM_W-1:0]   lane_sum [4];
  logic [ENTRY_W-1:0] lane_res [4];
  logic [3:0]         lane_busy;
  logic [3:0]         lane_done;
  logic [ENTRY_W-1:0] ident_entry;

  // write data select
  always_comb begin
    case (cmd.wr_src)
      WR_LEAF: wr_mat = item;
      WR_ACC:  wr_mat = acc;
      default: wr_mat = '0;
    endcase
  end

  rmp_ram #(
    .WIDTH(MAT_W),
    .DEPTH(SLOTS)
  ) u_nodes (
    .clk  (clk),
    .we   (cmd.wr_en),
    .waddr(node_addr),
    .wdata(wr_mat),
    .re   (cmd.rd_en),
    .raddr(node_addr),
    .rdata(rd_mat)
  );

  // capture the loaded matrix on input transfer
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      item <= item_mat;
    end
  end

  // eight partial products of acc x node, registered
  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      prod[0] <= PROD_W'(acc.tl) * PROD_W'(rd_mat.tl);
      prod[1] <= PROD_W'(acc.tr) * PROD_W'(rd_mat.bl);
      prod[2] <= PROD_W'(acc.tl) * PROD_W'(rd_mat.tr);
      prod[3] <= PROD_W'(acc.tr) * PROD_W'(rd_mat.br);
      prod[4] <= PROD_W'(acc.bl) * PROD_W'(rd_mat.tl);
      prod[5] <= PROD_W'(acc.br) * PROD_W'(rd_mat.bl);
      prod[6] <= PROD_W'(acc.bl) * PROD_W'(rd_mat.tr);
      prod[7] <= PROD_W'(acc.br) * PROD_W'(rd_mat.br);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= cmd.mul_start;
    end
  end

  // one reduction lane per result entry
  for (genvar k = 0; k < 4; k++) begin : g_lane
    assign lane_sum[k] = {1'b0, prod[2*k]} + {1'b0, prod[2*k+1]};

    rmp_modred u_red (
      .clk     (clk),
      .rst     (rst),
      .start   (p_valid),
      .dividend(lane_sum[k]),
      .modulus (modulus_eff),
      .busy    (lane_busy[k]),
      .done    (lane_done[k]),
      .result  (lane_res[k])
    );
  end

  assign stat.mul_busy = p_valid || (|lane_busy);
  assign stat.mul_done = &lane_done;

  // identity entry: reduced when the walk may split the root, raw otherwise
  assign ident_entry = (cmd.acc_ident_red && (modulus_eff == (ENTRY_W + 1)'(1))) ?
                       '0 : ENTRY_W'(1);

  // accumulator update
  always_ff @(posedge clk) begin
    if (cmd.acc_ident) begin
      acc <= '{tl: ident_entry, tr: '0, bl: '0, br: ident_entry};
    end else if (cmd.acc_from_rd) begin
      acc <= rd_mat;
    end else if (lane_done[0]) begin
      acc <= '{tl: lane_res[0], tr: lane_res[1], bl: lane_res[2], br: lane_res[3]};
    end
  end

  assign acc_out = acc;

endmodule

FILE: design/rmp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmp_ctrl
// Tree walk sequencer: clear pass, leaf load with ancestor update, range query.
// ----------------------------------------------------------------------------
module rmp_ctrl
  import rmp_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024,
  localparam int CNT_W = ($clog2(MAX_ELEMENTS + 1) > CNT_MIN_W) ?
                         $clog2(MAX_ELEMENTS + 1) : CNT_MIN_W
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              clear_req,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_req_type,
  input  logic [IDX_W-1:0]                  in_first,
  input  logic [IDX_W-1:0]                  in_last,
  input  logic [CNT_W-1:0]                  count_eff,
  input  logic                              out_free,
  output logic                              out_load,
  output dp_cmd_t                           cmd,
  input  dp_stat_t                          stat,
  output logic [$clog2(2*MAX_ELEMENTS)-1:0] node_addr
);

  localparam int SLOT_W = $clog2(2 * MAX_ELEMENTS);
  localparam int DEPTH  = CNT_W + 1;
  localparam int SP_W   = $clog2(DEPTH + 1);
  localparam int STK_IW = $clog2(DEPTH);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(2 * MAX_ELEMENTS - 1);

  typedef enum logic [14:0] {
    ST_CLEAR   = 15'b000000000000001,
    ST_IDLE    = 15'b000000000000010,
    ST_Q_STEP  = 15'b000000000000100,
    ST_Q_READ  = 15'b000000000001000,
    ST_Q_MUL   = 15'b000000000010000,
    ST_Q_NEXT  = 15'b000000000100000,
    ST_OUT     = 15'b000000001000000,
    ST_L_DOWN  = 15'b000000010000000,
    ST_L_LEAF  = 15'b000000100000000,
    ST_L_UP    = 15'b000001000000000,
    ST_L_RDL   = 15'b000010000000000,
    ST_L_RDR   = 15'b000100000000000,
    ST_L_MULS  = 15'b001000000000000,
    ST_L_MUL   = 15'b010000000000000,
    ST_L_WRITE = 15'b100000000000000
  } state_t;

  state_t            state, state_next;
  logic [SLOT_W-1:0] cur_s, cur_s_next;
  logic [CNT_W-1:0]  cur_l, cur_l_next;
  logic [CNT_W-1:0]  cur_r, cur_r_next;
  logic [SP_W-1:0]   sp, sp_next;
  logic [IDX_W-1:0]  q_b;
  logic [IDX_W-1:0]  q_e;
  logic [SLOT_W-1:0] stk_s [DEPTH];
  logic [CNT_W-1:0]  stk_l [DEPTH];
  logic [CNT_W-1:0]  stk_r [DEPTH];
  logic              push;
  logic [SLOT_W-1:0] push_s;
  logic [CNT_W-1:0]  push_l;
  logic [CNT_W-1:0]  push_r;
  logic [SP_W-1:0]   sp_m1;
  logic [CNT_W-1:0]  mid;
  logic [SLOT_W-1:0] left_s;
  logic [SLOT_W-1:0] right_s;
  logic [CNT_W-1:0]  b_ext;
  logic [CNT_W-1:0]  e_ext;
  logic              covered;
  logic              disjoint;

  // node geometry of the current position
  always_comb begin
    mid      = cur_l + ((cur_r - cur_l) >> 1);
    left_s   = cur_s + SLOT_W'(1);
    right_s  = cur_s + (SLOT_W'(mid - cur_l + CNT_W'(1)) << 1);
    b_ext    = CNT_W'(q_b);
    e_ext    = CNT_W'(q_e);
    covered  = (b_ext <= cur_l) && (cur_r <= e_ext);
    disjoint = (e_ext < cur_l) || (cur_r < b_ext);
    sp_m1    = sp - SP_W'(1);
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cur_s_next = cur_s;
    cur_l_next = cur_l;
    cur_r_next = cur_r;
    sp_next    = sp;
    push       = 1'b0;
    push_s     = cur_s;
    push_l     = cur_l;
    push_r     = cur_r;
    cmd        = '0;
    cmd.wr_src = WR_ZERO;
    node_addr  = cur_s;
    out_load   = 1'b0;
    in_ready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = WR_ZERO;
        cur_s_next = cur_s + SLOT_W'(1);
        if (cur_s == SLOT_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_item     = 1'b1;
          cmd.acc_ident     = 1'b1;
          // a range that starts inside the array goes through the root split
          cmd.acc_ident_red = (CNT_W'(in_first) < count_eff);
          cur_s_next        = '0;
          cur_l_next        = '0;
          cur_r_next        = count_eff - CNT_W'(1);
          sp_next           = '0;
          if (in_req_type) begin
            state_next = ST_Q_STEP;
          end else if (CNT_W'(in_first) < count_eff) begin
            state_next = ST_L_DOWN;
          end
        end
      end
      ST_Q_STEP: begin
        if (covered) begin
          cmd.rd_en  = 1'b1;
          state_next = ST_Q_READ;
        end else if (disjoint) begin
          state_next = ST_Q_NEXT;
        end else begin
          // right half waits on the stack, descend left
          push       = 1'b1;
          push_s     = right_s;
          push_l     = mid + CNT_W'(1);
          push_r     = cur_r;
          sp_next    = sp + SP_W'(1);
          cur_s_next = left_s;
          cur_r_next = mid;
        end
      end
      ST_Q_READ: begin
        // a whole-tree hit returns the root as stored
        if (cur_s == '0) begin
          cmd.acc_from_rd = 1'b1;
          state_next      = ST_Q_NEXT;
        end else begin
          cmd.mul_start = 1'b1;
          state_next    = ST_Q_MUL;
        end
      end
      ST_Q_MUL: begin
        if (stat.mul_done) begin
          state_next = ST_Q_NEXT;
        end
      end
      ST_Q_NEXT: begin
        if (sp == '0) begin
          state_next = ST_OUT;
        end else begin
          cur_s_next = stk_s[sp_m1[STK_IW-1:0]];
          cur_l_next = stk_l[sp_m1[STK_IW-1:0]];
          cur_r_next = stk_r[sp_m1[STK_IW-1:0]];
          sp_next    = sp_m1;
          state_next = ST_Q_STEP;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_L_DOWN: begin
        if (cur_l == cur_r) begin
          state_next = ST_L_LEAF;
        end else begin
          push    = 1'b1;
          sp_next = sp + SP_W'(1);
          if (b_ext <= mid) begin
            cur_s_next = left_s;
            cur_r_next = mid;
          end else begin
            cur_s_next = right_s;
            cur_l_next = mid + CNT_W'(1);
          end
        end
      end
      ST_L_LEAF: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = WR_LEAF;
        state_next = ST_L_UP;
      end
      ST_L_UP: begin
        if (sp == '0) begin
          state_next = ST_IDLE;
        end else begin
          cur_s_next = stk_s[sp_m1[STK_IW-1:0]];
          cur_l_next = stk_l[sp_m1[STK_IW-1:0]];
          cur_r_next = stk_r[sp_m1[STK_IW-1:0]];
          sp_next    = sp_m1;
          state_next = ST_L_RDL;
        end
      end
      ST_L_RDL: begin
        cmd.rd_en  = 1'b1;
        node_addr  = left_s;
        state_next = ST_L_RDR;
      end
      ST_L_RDR: begin
        cmd.acc_from_rd = 1'b1;
        cmd.rd_en       = 1'b1;
        node_addr       = right_s;
        state_next      = ST_L_MULS;
      end
      ST_L_MULS: begin
        cmd.mul_start = 1'b1;
        state_next    = ST_L_MUL;
      end
      ST_L_MUL: begin
        if (stat.mul_done) begin
          state_next = ST_L_WRITE;
        end
      end
      ST_L_WRITE: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = WR_ACC;
        state_next = ST_L_UP;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    // a count write restarts the clearing pass
    if (clear_req) begin
      state_next = ST_CLEAR;
      cur_s_next = '0;
      sp_next    = '0;
      push       = 1'b0;
      cmd        = '0;
      cmd.wr_src = WR_ZERO;
      in_ready   = 1'b0;
      out_load   = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cur_s <= '0;
      sp    <= '0;
    end else begin
      state <= state_next;
      cur_s <= cur_s_next;
      sp    <= sp_next;
    end
  end

  // walk bounds, query range and node stack
  always_ff @(posedge clk) begin
    cur_l <= cur_l_next;
    cur_r <= cur_r_next;
    if (cmd.take_item) begin
      q_b <= in_first;
      q_e <= in_last;
    end
    if (push) begin
      stk_s[sp[STK_IW-1:0]] <= push_s;
      stk_l[sp[STK_IW-1:0]] <= push_l;
      stk_r[sp[STK_IW-1:0]] <= push_r;
    end
  end

  // node memory has a single access per cycle
  assert property (@(posedge clk) disable iff (rst) !(cmd.rd_en && cmd.wr_en))
    else $error("node read and write in the same cycle");

  // a started multiply keeps the datapath busy on the next cycle
  assert property (@(posedge clk) disable iff (rst) cmd.mul_start |=> stat.mul_busy)
    else $error("multiply start not seen by datapath");

  // a result is only handed out after the walk has emptied the stack
  assert property (@(posedge clk) disable iff (rst) out_load |-> (sp == '0))
    else $error("result issued with pending tree nodes");

endmodule

FILE: verif/range_matrix_product_mod_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_matrix_product_mod_checker
// Watches the config port and both streams, keeps its own segment tree of
// 2x2 matrices, predicts each query product and compares it field by field.
// ----------------------------------------------------------------------------
module range_matrix_product_mod_checker
  import rmp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic         pready,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [143:0] s_tdata,
  input  logic [0:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [119:0] m_tdata,
  output int           fail_count,
  output int           pending_count
);

  localparam int SLOTS = 2048;
  localparam int LIMIT_ELEMENTS = 1024;

  logic [ENTRY_W-1:0] tree_tl [SLOTS];
  logic [ENTRY_W-1:0] tree_tr [SLOTS];
  logic [ENTRY_W-1:0] tree_bl [SLOTS];
  logic [ENTRY_W-1:0] tree_br [SLOTS];
  logic [ENTRY_W-1:0] cur_modulus;
  logic [10:0]        cur_count;
  mat_t               product_queue[$];

  assign pending_count = product_queue.size();

  function automatic void clear_tree();
    for (int i = 0; i < SLOTS; i++) begin
      tree_tl[i] = '0;
      tree_tr[i] = '0;
      tree_bl[i] = '0;
      tree_br[i] = '0;
    end
  endfunction

  function automatic int used_count();
    if (cur_count == 0) return 1;
    if (cur_count > LIMIT_ELEMENTS) return LIMIT_ELEMENTS;
    return int'(cur_count);
  endfunction

  // modular 2x2 product, zero modulus means 2^30
  function automatic mat_t mod_mul(mat_t x, mat_t y);
    longint unsigned m;
    mat_t z;
    m = (cur_modulus == 0) ? 64'h4000_0000 : 64'(cur_modulus);
    z.tl = ENTRY_W'((64'(x.tl) * y.tl + 64'(x.tr) * y.bl) % m);
    z.tr = ENTRY_W'((64'(x.tl) * y.tr + 64'(x.tr) * y.br) % m);
    z.bl = ENTRY_W'((64'(x.bl) * y.tl + 64'(x.br) * y.bl) % m);
    z.br = ENTRY_W'((64'(x.bl) * y.tr + 64'(x.br) * y.br) % m);
    return z;
  endfunction

  function automatic mat_t node_get(int s);
    mat_t v;
    v.tl = tree_tl[s];
    v.tr = tree_tr[s];
    v.bl = tree_bl[s];
    v.br = tree_br[s];
    return v;
  endfunction

  function automatic void node_put(int s, mat_t v);
    tree_tl[s] = v.tl;
    tree_tr[s] = v.tr;
    tree_bl[s] = v.bl;
    tree_br[s] = v.br;
  endfunction

  // write one leaf and rebuild its ancestors, left child first
  function automatic void leaf_update(int s, int l, int r, int pos, mat_t v);
    int mid;
    int rs;
    if (l == r) begin
      node_put(s, v);
      return;
    end
    mid = l + (r - l) / 2;
    rs = s + 2 * (mid - l + 1);
    if (pos <= mid) leaf_update(s + 1, l, mid, pos, v);
    else leaf_update(rs, mid + 1, r, pos, v);
    node_put(s, mod_mul(node_get(s + 1), node_get(rs)));
  endfunction

  function automatic mat_t span_product(int s, int l, int r, int b, int e);
    int mid;
    mat_t ident;
    if (b <= l && r <= e) return node_get(s);
    if (e < l || r < b) begin
      ident = '{tl: 1, tr: 0, bl: 0, br: 1};
      return ident;
    end
    mid = l + (r - l) / 2;
    return mod_mul(span_product(s + 1, l, mid, b, e),
                   span_product(s + 2 * (mid - l + 1), mid + 1, r, b, e));
  endfunction

  always @(posedge clk) begin
    mat_t got;
    mat_t want;
    mat_t item_mat;
    int   first_idx;
    int   last_idx;
    if (rst) begin
      clear_tree();
      cur_modulus = MOD_RESET;
      cur_count   = 11'd1024;
      product_queue.delete();
      fail_count  = 0;
    end else begin
      // result transfer against the oldest prediction
      if (m_tvalid && m_tready) begin
        got.tl = m_tdata[29:0];
        got.tr = m_tdata[59:30];
        got.bl = m_tdata[89:60];
        got.br = m_tdata[119:90];
        if (product_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result with none expected: %h", $realtime, got);
        end else begin
          want = product_queue.pop_front();
          if (got.tl !== want.tl || got.tr !== want.tr ||
              got.bl !== want.bl || got.br !== want.br) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"%0t: product mismatch exp tl=%0d tr=%0d bl=%0d br=%0d",
                        " got tl=%0d tr=%0d bl=%0d br=%0d"},
                       $realtime, want.tl, want.tr, want.bl, want.br,
                       got.tl, got.tr, got.bl, got.br);
          end
        end
      end
      // request transfer
      if (s_tvalid && s_tready) begin
        first_idx = int'(s_tdata[9:0]);
        last_idx  = int'(s_tdata[19:10]);
        if (s_tuser[0] == 1'b0) begin
          item_mat.tl = s_tdata[49:20];
          item_mat.tr = s_tdata[79:50];
          item_mat.bl = s_tdata[109:80];
          item_mat.br = s_tdata[139:110];
          if (first_idx < used_count())
            leaf_update(0, 0, used_count() - 1, first_idx, item_mat);
        end else begin
          want = span_product(0, 0, used_count() - 1, first_idx, last_idx);
          product_queue = {product_queue, want};
        end
      end
      // register write
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_MODULUS) begin
          cur_modulus = pwdata[29:0];
        end else begin
          cur_count = pwdata[10:0];
          clear_tree();
        end
      end
    end
  end

endmodule

FILE: verif/range_matrix_product_mod_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_matrix_product_mod_tb
// Drives loads and range queries through several modulus and count settings
// with random gaps and stalls; the checker predicts and compares products.
// ----------------------------------------------------------------------------
module range_matrix_product_mod_tb;
  import rmp_pkg::*;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;
  localparam int   CYCLE_LIMIT = 8000000;
  localparam int   SETTLE_CYCLES = 1500;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // first_index, last_index, entry tl, tr, bl, br, zero pad
  logic [143:0] s_tdata = '0;
  // req_type
  logic [0:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // product tl, tr, bl, br
  logic [119:0] m_tdata;

  int  fail_count;
  int  pending_count;
  int  cycle_count = 0;
  bit  hold_request = 0;
  bit  sender_quiet = 0;
  bit  receiver_quiet = 0;
  int  model_count = 1024;
  longint model_modulus = 998244353;

  always #1 clk = ~clk;

  range_matrix_product_mod dut (.*);

  range_matrix_product_mod_checker checker_i (
    .clk, .rst, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata,
    .fail_count, .pending_count
  );

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int w;
    @(posedge clk iff !rst);
    forever begin
      if ($urandom_range(0, 39) == 0) receiver_quiet = !receiver_quiet;
      w = receiver_quiet ? 0 : $urandom_range(0, 10);
      if (hold_request) begin
        hold_request = 0;
        w = 4000;
      end
      if (w > 0) begin
        m_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk iff (m_tvalid && m_tready));
    end
  end

  task automatic send_item(logic kind, int first_idx, int last_idx,
                           logic [29:0] tl, logic [29:0] tr,
                           logic [29:0] bl, logic [29:0] br);
    int w;
    if ($urandom_range(0, 39) == 0) sender_quiet = !sender_quiet;
    w = sender_quiet ? 0 : $urandom_range(0, 10);
    if (w > 0) begin
      s_tvalid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    s_tuser  <= kind;
    s_tdata  <= {4'b0, br, bl, tr, tl, 10'(last_idx), 10'(first_idx)};
    s_tvalid <= 1'b1;
    @(posedge clk iff (s_tvalid && s_tready));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(logic addr_sel, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {addr_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (addr_sel == REG_MODULUS) begin
      model_modulus = value[29:0];
    end else begin
      model_count = (value[10:0] == 0) ? 1 : (value[10:0] > 1024) ? 1024 : value[10:0];
    end
  endtask

  function automatic logic [29:0] rand_entry();
    longint m;
    m = (model_modulus == 0) ? 64'h4000_0000 : model_modulus;
    if ($urandom_range(0, 9) == 0) return 30'($urandom);
    return 30'(longint'($urandom) % m);
  endfunction

  // mostly in-range loads and queries, some out-of-range noise
  task automatic random_items(int n_items, int pause_at);
    int a;
    int b;
    int t;
    for (int i = 0; i < n_items; i++) begin
      if (i == pause_at) drain();
      if ($urandom_range(0, 1) == 0) begin
        a = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                        : $urandom_range(0, model_count - 1);
        send_item(REQ_LOAD, a, $urandom_range(0, 1023), rand_entry(),
                  rand_entry(), rand_entry(), rand_entry());
      end else begin
        if ($urandom_range(0, 7) == 0) begin
          a = $urandom_range(0, 1023);
          b = $urandom_range(0, 1023);
        end else begin
          a = $urandom_range(0, model_count - 1);
          b = $urandom_range(0, model_count - 1);
          if (a > b) begin
            t = a;
            a = b;
            b = t;
          end
        end
        send_item(REQ_QUERY, a, b, 30'($urandom), 30'($urandom),
                  30'($urandom), 30'($urandom));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed items at reset settings
    send_item(REQ_QUERY, 0, 1023, '0, '0, '0, '0);
    send_item(REQ_LOAD, 0, 0, 30'd1073741822, 30'd0, 30'd5, 30'd1073741822);
    send_item(REQ_LOAD, 1023, 1023, 30'd2, 30'd3, 30'd4, 30'd998244352);
    send_item(REQ_LOAD, 1, 0, 30'd1, 30'd1, 30'd1, 30'd0);
    send_item(REQ_QUERY, 0, 0, '0, '0, '0, '0);
    send_item(REQ_QUERY, 0, 1023, '0, '0, '0, '0);
    send_item(REQ_QUERY, 0, 1, '1, '1, '1, '1);
    send_item(REQ_QUERY, 1023, 1023, '0, '0, '0, '0);
    send_item(REQ_QUERY, 5, 2, '0, '0, '0, '0);
    send_item(REQ_QUERY, 1, 1023, '0, '0, '0, '0);
    drain();

    // small array: load beyond count, range past the end, reversed range
    reg_write(REG_MODULUS, 32'd13);
    reg_write(REG_COUNT, 32'd5);
    send_item(REQ_LOAD, 7, 0, 30'd1, 30'd2, 30'd3, 30'd4);
    send_item(REQ_LOAD, 2, 0, 30'd20, 30'd2, 30'd3, 30'd4);
    send_item(REQ_LOAD, 3, 0, 30'd12, 30'd11, 30'd1, 30'd9);
    send_item(REQ_QUERY, 2, 2, '0, '0, '0, '0);
    send_item(REQ_QUERY, 2, 1023, '0, '0, '0, '0);
    send_item(REQ_QUERY, 6, 9, '0, '0, '0, '0);
    send_item(REQ_QUERY, 4, 1, '0, '0, '0, '0);
    random_items(80, -1);
    drain();

    // modulus change keeps stored nodes
    reg_write(REG_MODULUS, 32'd97);
    random_items(50, -1);
    drain();

    reg_write(REG_MODULUS, 32'd0);
    reg_write(REG_COUNT, 32'd1);
    random_items(50, -1);
    drain();

    // count of zero acts as one
    reg_write(REG_MODULUS, 32'h3FFF_FFFF);
    reg_write(REG_COUNT, 32'd0);
    random_items(30, -1);
    drain();

    // count above the maximum saturates
    reg_write(REG_MODULUS, 32'd1);
    reg_write(REG_COUNT, 32'h7FF);
    random_items(30, -1);
    drain();

    // long result stall while requests keep coming
    reg_write(REG_MODULUS, 32'd998244353);
    reg_write(REG_COUNT, 32'd37);
    hold_request = 1;
    random_items(150, -1);
    drain();

    // sender pause until all products arrive
    reg_write(REG_MODULUS, 32'd65537);
    reg_write(REG_COUNT, 32'd1024);
    random_items(80, 40);
    drain();

    reg_write(REG_MODULUS, 32'd1000003);
    reg_write(REG_COUNT, 32'd200);
    random_items(180, -1);
    drain();

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
